// ===== hw/rtl/swpl_pkg.sv =====
// shared types and constants for the stopwatch press-length block
package swpl_pkg;

  // elapsed-time wrap point in centiseconds (100 hours)
  localparam logic [25:0] WRAP_TICKS = 26'd36000000;
  localparam logic [6:0]  CENTI_LAST  = 7'd99;
  localparam logic [5:0]  SECOND_LAST = 6'd59;
  localparam logic [5:0]  MINUTE_LAST = 6'd59;
  localparam logic [6:0]  HOUR_LAST   = 7'd99;
  localparam logic [7:0]  LAP_MAX     = 8'd255;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TIME = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_ENABLE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_ENABLE    = 2'd3;

  // configuration reset values
  localparam logic [7:0] POLL_PERIOD_RST     = 8'd10;
  localparam logic [9:0] LONG_PRESS_TIME_RST = 10'd50;

  // press state machine
  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_LAP       = 5'b00010,
    ST_SHORT     = 5'b00100,
    ST_STOPRESET = 5'b01000,
    ST_LONG      = 5'b10000
  } press_state_t;

  // elapsed time fields
  typedef struct packed {
    logic [6:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [6:0] centis;
  } time_t;

  // control from the press machine to the time counters
  typedef struct packed {
    logic step;
    logic run;
    logic clear;
  } time_ctrl_t;

  // one result beat
  typedef struct packed {
    logic [7:0] lap_number;
    logic       lap_valid;
    logic       led_on;
    logic       running;
    logic [6:0] centis;
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [6:0] hours;
  } result_t;

endpackage

// ===== hw/rtl/swpl_time.sv =====
// cascaded elapsed-time counters and the running tick count
module swpl_time (
  input  logic               clk,
  input  logic               rst,
  input  swpl_pkg::time_ctrl_t ctrl,
  output logic [25:0]        total_adv,
  output swpl_pkg::time_t    time_next
);

  logic [25:0]     total;
  swpl_pkg::time_t count;
  swpl_pkg::time_t count_adv;
  logic [25:0]     total_next;

  // advance by one centisecond when running
  always_comb begin
    count_adv = count;
    total_adv = total;
    if (ctrl.run) begin
      total_adv = (total == swpl_pkg::WRAP_TICKS - 26'd1) ? 26'd0 : total + 26'd1;
      if (count.centis != swpl_pkg::CENTI_LAST) begin
        count_adv.centis = count.centis + 7'd1;
      end else begin
        count_adv.centis = 7'd0;
        if (count.seconds != swpl_pkg::SECOND_LAST) begin
          count_adv.seconds = count.seconds + 6'd1;
        end else begin
          count_adv.seconds = 6'd0;
          if (count.minutes != swpl_pkg::MINUTE_LAST) begin
            count_adv.minutes = count.minutes + 6'd1;
          end else begin
            count_adv.minutes = 6'd0;
            count_adv.hours = (count.hours >= swpl_pkg::HOUR_LAST) ? 7'd0
                                                                    : count.hours + 7'd1;
          end
        end
      end
    end
  end

  // stop-and-reset clears after the advance
  always_comb begin
    time_next  = ctrl.clear ? '0 : count_adv;
    total_next = ctrl.clear ? 26'd0 : total_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      total <= 26'd0;
    end else if (ctrl.step) begin
      count <= time_next;
      total <= total_next;
    end
  end

`ifndef SYNTH
  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    (ctrl.step && ctrl.clear) |=> (count == '0 && total == 26'd0))
    else $error("time not cleared after stop and reset");

  a_time_range: assert property (@(posedge clk) disable iff (rst)
    ctrl.step |=> (count.centis <= swpl_pkg::CENTI_LAST &&
                   count.seconds <= swpl_pkg::SECOND_LAST &&
                   count.minutes <= swpl_pkg::MINUTE_LAST &&
                   count.hours <= swpl_pkg::HOUR_LAST &&
                   total < swpl_pkg::WRAP_TICKS))
    else $error("time counter out of range");
`endif

endmodule

// ===== hw/rtl/swpl_press.sv =====
// press state machine with poll divider, lap count and long-press detect
module swpl_press (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 pressed,
  input  logic [7:0]           poll_period,
  input  logic [9:0]           long_press_time,
  input  logic [25:0]          total_adv,
  output swpl_pkg::time_ctrl_t ctrl,
  output logic                 running_next,
  output logic                 led_next,
  output logic                 lap_valid_next,
  output logic [7:0]           lap_number_next
);

  swpl_pkg::press_state_t press_state;
  swpl_pkg::press_state_t press_state_next;
  logic        running;
  logic [25:0] press_start;
  logic [25:0] press_start_next;
  logic [7:0]  lap_count;
  logic [7:0]  poll_divider;
  logic [7:0]  poll_divider_next;
  logic [7:0]  div_inc;
  logic [7:0]  period;
  logic        eval;
  logic [26:0] diff;
  logic [25:0] held;
  logic        is_long;

  // poll divider, a zero period acts as one
  always_comb begin
    period            = (poll_period == 8'd0) ? 8'd1 : poll_period;
    div_inc           = poll_divider + 8'd1;
    eval              = (div_inc >= period);
    poll_divider_next = eval ? 8'd0 : div_inc;
  end

  // held time modulo the wrap point
  always_comb begin
    diff    = {1'b0, total_adv} - {1'b0, press_start};
    held    = diff[26] ? diff[25:0] + swpl_pkg::WRAP_TICKS : diff[25:0];
    is_long = (held >= {16'd0, long_press_time});
  end

  // next state of the press machine
  always_comb begin
    press_state_next = press_state;
    press_start_next = press_start;
    running_next     = running;
    lap_number_next  = lap_count;
    lap_valid_next   = 1'b0;
    ctrl.clear       = 1'b0;
    if (eval) begin
      unique case (press_state)
        swpl_pkg::ST_IDLE: begin
          if (pressed) begin
            press_start_next = total_adv;
            press_state_next = swpl_pkg::ST_LAP;
          end
        end
        swpl_pkg::ST_LAP: begin
          if (!running) begin
            running_next    = 1'b1;
            lap_number_next = 8'd0;
          end else begin
            if (lap_count != swpl_pkg::LAP_MAX) begin
              lap_number_next = lap_count + 8'd1;
            end
            lap_valid_next = 1'b1;
          end
          press_state_next = pressed ? swpl_pkg::ST_SHORT : swpl_pkg::ST_IDLE;
        end
        swpl_pkg::ST_SHORT: begin
          if (!pressed) begin
            press_state_next = swpl_pkg::ST_IDLE;
          end else if (is_long) begin
            press_state_next = swpl_pkg::ST_STOPRESET;
          end
        end
        swpl_pkg::ST_STOPRESET: begin
          running_next     = 1'b0;
          ctrl.clear       = 1'b1;
          press_state_next = pressed ? swpl_pkg::ST_LONG : swpl_pkg::ST_IDLE;
        end
        swpl_pkg::ST_LONG: begin
          if (!pressed) begin
            press_state_next = swpl_pkg::ST_IDLE;
          end
        end
        default: begin
          press_state_next = swpl_pkg::ST_IDLE;
        end
      endcase
    end
    led_next  = (press_state_next != swpl_pkg::ST_IDLE);
    ctrl.step = step;
    ctrl.run  = running;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      press_state  <= swpl_pkg::ST_IDLE;
      running      <= 1'b0;
      press_start  <= 26'd0;
      lap_count    <= 8'd0;
      poll_divider <= 8'd0;
    end else if (step) begin
      press_state  <= press_state_next;
      running      <= running_next;
      press_start  <= press_start_next;
      lap_count    <= lap_number_next;
      poll_divider <= poll_divider_next;
    end
  end

`ifndef SYNTH
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !(step && eval) |=> $stable(press_state))
    else $error("press state moved without an evaluation");

  a_start_clears_laps: assert property (@(posedge clk) disable iff (rst)
    (step && eval && press_state == swpl_pkg::ST_LAP && !running)
      |=> (running && lap_count == 8'd0))
    else $error("start did not clear the lap count");

  a_lap_when_running: assert property (@(posedge clk) disable iff (rst)
    (step && lap_valid_next) |-> running)
    else $error("lap recorded while stopped");
`endif

endmodule

// ===== hw/rtl/stopwatch_press_length_fsm.sv =====
// top level of the stopwatch with lap recording and long-press reset
//
// Each input beat on s_* is one centisecond tick carrying the raw button
// level (bit 0, low means pressed) and the touch flag (bit 1). Every tick
// gives exactly one result beat on m_* with the elapsed time, the running
// and led flags, a lap strobe and the lap count, as they stand after that
// tick. The press machine is evaluated on every poll_period-th tick.
// Configuration: cfg_wr_en with cfg_index 0 poll_period, 1 long_press_time,
// 2 button_enable, 3 touch_enable; write only while no tick is in flight.
// Path: a tick is captured in the input register and written to the result
// register, from which its result beat is taken (one input register, one
// result register, the counters and the press machine in the single logic
// stage between them).
// Throughput: one tick per cycle; s_tready stays high while the result
// register is taken or empty, so a full tick pair is held when m_tready is
// low and the input side stalls only once both registers are occupied.
// Reset (rst, synchronous): watch stopped at 00:00:00.00, press machine
// idle, lap count zero, registers at their defaults, both channels empty.
module stopwatch_press_length_fsm (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  // tick input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,  // button_level, touch_flag, zero fill
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  // hours[6:0], minutes[12:7], seconds[18:13], centis[25:19], running[26],
  // led_on[27], lap_valid[28], lap_number[36:29], zero fill
  output logic [39:0] m_tdata
);

  logic [7:0] poll_period;
  logic [9:0] long_press_time;
  logic       button_enable;
  logic       touch_enable;

  logic       in_valid;
  logic       in_button;
  logic       in_touch;
  logic       out_valid;
  swpl_pkg::result_t out_data;

  logic                 advance;
  logic                 pressed;
  logic [25:0]          total_adv;
  swpl_pkg::time_t      time_next;
  swpl_pkg::time_ctrl_t ctrl;
  logic                 running_next;
  logic                 led_next;
  logic                 lap_valid_next;
  logic [7:0]           lap_number_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_period     <= swpl_pkg::POLL_PERIOD_RST;
      long_press_time <= swpl_pkg::LONG_PRESS_TIME_RST;
      button_enable   <= 1'b1;
      touch_enable    <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        swpl_pkg::CFG_POLL_PERIOD:     poll_period     <= cfg_data[7:0];
        swpl_pkg::CFG_LONG_PRESS_TIME: long_press_time <= cfg_data;
        swpl_pkg::CFG_BUTTON_ENABLE:   button_enable   <= cfg_data[0];
        swpl_pkg::CFG_TOUCH_ENABLE:    touch_enable    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake: a tick is processed when the result register can take it
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_button <= s_tdata[0];
      in_touch  <= s_tdata[1];
    end
  end

  // press sources
  assign pressed = (button_enable && !in_button) || (touch_enable && in_touch);

  swpl_press u_press (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .pressed         (pressed),
    .poll_period     (poll_period),
    .long_press_time (long_press_time),
    .total_adv       (total_adv),
    .ctrl            (ctrl),
    .running_next    (running_next),
    .led_next        (led_next),
    .lap_valid_next  (lap_valid_next),
    .lap_number_next (lap_number_next)
  );

  swpl_time u_time (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .total_adv (total_adv),
    .time_next (time_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.hours      <= time_next.hours;
      out_data.minutes    <= time_next.minutes;
      out_data.seconds    <= time_next.seconds;
      out_data.centis     <= time_next.centis;
      out_data.running    <= running_next;
      out_data.led_on     <= led_next;
      out_data.lap_valid  <= lap_valid_next;
      out_data.lap_number <= lap_number_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_data};

endmodule
